@@ src/fmls_pkg.sv @@
// Shared types and constants of the frame mean luma sampler.
`timescale 1ns / 1ps

package fmls_pkg;

   localparam int CH_W        = 8;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int TOTAL_W     = 38;
   localparam int TALLY_W     = 14;
   localparam int MEAN_W      = 16;
   localparam int Y_W         = 24;
   localparam int DIV_W       = TALLY_W + 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int RESET_SIDE  = 64;

   // Rec.601 luma weights in Q16, summing to 65536
   localparam int WEIGHT_R = 19595;
   localparam int WEIGHT_G = 38470;
   localparam int WEIGHT_B = 7471;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_RED_FIRST    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CH_W-1:0] first_channel;
      logic [CH_W-1:0] middle_channel;
      logic [CH_W-1:0] third_channel;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0]  mean_brightness;
      logic [TALLY_W-1:0] samples_taken;
   } rsp_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] luma_total;
      logic [TALLY_W-1:0] sample_tally;
   } frame_sum_type;

   typedef struct packed {
      logic full;
      logic almost_full;
      logic empty;
   } queue_status_type;

endpackage

@@ src/fmls_queue.sv @@
// Short queue of finished frame sums between the pixel front end and the divider.
`timescale 1ns / 1ps

module fmls_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  fmls_pkg::frame_sum_type      push_data,
   input  logic                         pop,
   output fmls_pkg::frame_sum_type      head,
   output fmls_pkg::queue_status_type   status
);
   import fmls_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_sum_type     store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.almost_full = (count_ff >= CNT_W'(QUEUE_DEPTH - 1));
   assign status.empty       = (count_ff == '0);

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/fmls_front.sv @@
// Pixel front end: settings, grid position tracking, luma weighting and frame sums.
`timescale 1ns / 1ps

module fmls_front #(
   parameter int GRID_CELLS = 64,
   parameter int MAX_SIDE   = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [fmls_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fmls_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_push,
   input  fmls_pkg::req_type                     req_data,
   output logic                                  req_full,
   output logic                                  q_push,
   output fmls_pkg::frame_sum_type               q_push_data,
   input  fmls_pkg::queue_status_type            q_status
);
   import fmls_pkg::*;

   localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
   localparam int IDX_W       = $clog2(MAX_SIDE);
   localparam int MAX_STEP    = MAX_SIDE / GRID_CELLS;
   localparam int STEP_W      = $clog2(MAX_STEP + 1);
   localparam int PHASE_W     = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
   localparam int CMP_W       = STEP_W + 1;
   localparam int RECIP_SHIFT = SIDE_W + $clog2(GRID_CELLS);
   localparam longint RECIP   = (longint'(1) << RECIP_SHIFT) / GRID_CELLS + 1;
   localparam int RECIP_W     = SIDE_W + 2;
   localparam int PROD_W      = SIDE_W + RECIP_W;
   localparam int RESET_STEP  = (RESET_SIDE / GRID_CELLS == 0) ? 1 : RESET_SIDE / GRID_CELLS;

   // Clamp a written side to 1..MAX_SIDE
   function automatic logic [SIDE_W-1:0] eff_side(input logic [CSR_DATA_W-1:0] v);
      logic [SIDE_W-1:0] r;
      if (v == '0) begin
         r = SIDE_W'(1);
      end else if (32'(v) > 32'(MAX_SIDE)) begin
         r = SIDE_W'(MAX_SIDE);
      end else begin
         r = SIDE_W'(v);
      end
      return r;
   endfunction

   // max(1, side / GRID_CELLS) by reciprocal multiplication, exact over the side range
   function automatic logic [STEP_W-1:0] step_of(input logic [SIDE_W-1:0] side);
      logic [PROD_W-1:0] prod;
      logic [STEP_W-1:0] q;
      prod = PROD_W'(side) * PROD_W'(RECIP);
      q    = STEP_W'(prod >> RECIP_SHIFT);
      return (q == '0) ? STEP_W'(1) : q;
   endfunction

   logic [SIDE_W-1:0]   width_ff, width_in;
   logic [SIDE_W-1:0]   height_ff, height_in;
   logic [STEP_W-1:0]   step_x_ff, step_x_in;
   logic [STEP_W-1:0]   step_y_ff, step_y_in;
   logic                red_first_ff, red_first_in;

   logic [IDX_W-1:0]    col_idx_ff, col_idx_in;
   logic [IDX_W-1:0]    row_idx_ff, row_idx_in;
   logic [PHASE_W-1:0]  col_phase_ff, col_phase_in;
   logic [PHASE_W-1:0]  row_phase_ff, row_phase_in;

   logic                s1_valid_ff, s1_valid_in;
   logic                s1_kept_ff, s1_kept_in;
   logic                s1_last_ff, s1_last_in;
   logic [Y_W-1:0]      s1_luma_ff, s1_luma_in;

   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in;

   logic                accept, kept, row_done, frame_done;
   logic [PHASE_W-1:0]  col_phase_next, row_phase_next;
   logic [CH_W-1:0]     red, blue;
   logic [TOTAL_W-1:0]  sum;
   logic [TALLY_W-1:0]  tally_sum;

   assign req_full = q_status.full || (q_status.almost_full && s1_valid_ff && s1_last_ff);
   assign accept   = req_push && !req_full;

   // settings
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      step_x_in    = step_x_ff;
      step_y_in    = step_y_ff;
      red_first_in = red_first_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH: begin
               width_in  = eff_side(csr_wdata);
               step_x_in = step_of(eff_side(csr_wdata));
            end
            CSR_FRAME_HEIGHT: begin
               height_in = eff_side(csr_wdata);
               step_y_in = step_of(eff_side(csr_wdata));
            end
            CSR_RED_FIRST: begin
               red_first_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // classify the pixel on the grid
   assign kept       = (col_phase_ff == '0) && (row_phase_ff == '0);
   assign row_done   = (SIDE_W'(col_idx_ff) + SIDE_W'(1)) >= width_ff;
   assign frame_done = row_done && ((SIDE_W'(row_idx_ff) + SIDE_W'(1)) >= height_ff);

   assign col_phase_next = ((CMP_W'(col_phase_ff) + CMP_W'(1)) >= CMP_W'(step_x_ff)) ?
                           '0 : col_phase_ff + PHASE_W'(1);
   assign row_phase_next = ((CMP_W'(row_phase_ff) + CMP_W'(1)) >= CMP_W'(step_y_ff)) ?
                           '0 : row_phase_ff + PHASE_W'(1);

   assign red  = red_first_ff ? req_data.first_channel : req_data.third_channel;
   assign blue = red_first_ff ? req_data.third_channel : req_data.first_channel;

   always_comb begin
      col_idx_in   = col_idx_ff;
      row_idx_in   = row_idx_ff;
      col_phase_in = col_phase_ff;
      row_phase_in = row_phase_ff;
      if (accept) begin
         if (!row_done) begin
            col_idx_in   = col_idx_ff + IDX_W'(1);
            col_phase_in = col_phase_next;
         end else begin
            col_idx_in   = '0;
            col_phase_in = '0;
            if (!frame_done) begin
               row_idx_in   = row_idx_ff + IDX_W'(1);
               row_phase_in = row_phase_next;
            end else begin
               row_idx_in   = '0;
               row_phase_in = '0;
            end
         end
      end
   end

   // weighting stage
   assign s1_valid_in = accept;
   assign s1_kept_in  = accept && kept;
   assign s1_last_in  = accept && frame_done;
   assign s1_luma_in  = Y_W'(red) * Y_W'(WEIGHT_R)
                      + Y_W'(req_data.middle_channel) * Y_W'(WEIGHT_G)
                      + Y_W'(blue) * Y_W'(WEIGHT_B);

   // accumulation stage
   assign sum       = total_ff + (s1_kept_ff ? TOTAL_W'(s1_luma_ff) : '0);
   assign tally_sum = tally_ff + (s1_kept_ff ? TALLY_W'(1) : '0);

   assign q_push                   = s1_valid_ff && s1_last_ff;
   assign q_push_data.luma_total   = sum;
   assign q_push_data.sample_tally = tally_sum;

   always_comb begin
      total_in = total_ff;
      tally_in = tally_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            total_in = '0;
            tally_in = '0;
         end else begin
            total_in = sum;
            tally_in = tally_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= SIDE_W'(RESET_SIDE);
         height_ff    <= SIDE_W'(RESET_SIDE);
         step_x_ff    <= STEP_W'(RESET_STEP);
         step_y_ff    <= STEP_W'(RESET_STEP);
         red_first_ff <= 1'b0;
         col_idx_ff   <= '0;
         row_idx_ff   <= '0;
         col_phase_ff <= '0;
         row_phase_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s1_kept_ff   <= 1'b0;
         s1_last_ff   <= 1'b0;
         total_ff     <= '0;
         tally_ff     <= '0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         step_x_ff    <= step_x_in;
         step_y_ff    <= step_y_in;
         red_first_ff <= red_first_in;
         col_idx_ff   <= col_idx_in;
         row_idx_ff   <= row_idx_in;
         col_phase_ff <= col_phase_in;
         row_phase_ff <= row_phase_in;
         s1_valid_ff  <= s1_valid_in;
         s1_kept_ff   <= s1_kept_in;
         s1_last_ff   <= s1_last_in;
         total_ff     <= total_in;
         tally_ff     <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_luma_ff <= s1_luma_in;
   end

endmodule

@@ src/fmls_back.sv @@
// Back end: serial restoring divider for the frame mean and the result register.
`timescale 1ns / 1ps

module fmls_back (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          q_pop,
   input  fmls_pkg::frame_sum_type       q_head,
   input  fmls_pkg::queue_status_type    q_status,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output fmls_pkg::rsp_type             rsp_data
);
   import fmls_pkg::*;

   localparam int BIT_W = $clog2(MEAN_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [TOTAL_W-1:0]  rem_ff, rem_in;
   logic [TOTAL_W-1:0]  dsh_ff, dsh_in;
   logic [MEAN_W-1:0]   quo_ff, quo_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [TALLY_W-1:0]  tally_ff, tally_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_data_ff, out_data_in;

   logic [DIV_W-1:0]    divisor;
   logic                ge, out_free;

   // tally * 255 without a multiplier
   assign divisor  = (DIV_W'(q_head.sample_tally) << 8) - DIV_W'(q_head.sample_tally);
   assign ge       = (rem_ff >= dsh_ff);
   assign out_free = !out_valid_ff || rsp_pop;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      tally_in     = tally_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               rem_in   = q_head.luma_total;
               tally_in = q_head.sample_tally;
               dsh_in   = TOTAL_W'(divisor) << MEAN_W;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // empty tally gives zero; a quotient past 16 bits saturates
            if (tally_ff == '0) begin
               quo_in   = '0;
               state_in = ST_FINISH;
            end else if (ge) begin
               quo_in   = '1;
               state_in = ST_FINISH;
            end else begin
               quo_in   = '0;
               dsh_in   = dsh_ff >> 1;
               bit_in   = BIT_W'(MEAN_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dsh_ff;
            end
            quo_in = {quo_ff[MEAN_W-2:0], ge};
            dsh_in = dsh_ff >> 1;
            if (bit_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in                = 1'b1;
               out_data_in.mean_brightness = quo_ff;
               out_data_in.samples_taken   = tally_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      bit_ff      <= bit_in;
      tally_ff    <= tally_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ src/frame_mean_luma_sampler.sv @@
// Frame mean luma sampler: grid-subsampled Rec.601 mean brightness per frame.
// Throughput: one pixel per cycle while req_full is low; the divider works through each frame result in
// its 16 quotient steps (skipped when the mean saturates or the tally is empty).
// A frame's sum passes the weighting register, the queue and the divider before it reaches the result register.
// Reset (synchronous, active high): 64 x 64 frame, B,G,R order, queue and sums cleared.
`timescale 1ns / 1ps

module frame_mean_luma_sampler #(
   parameter int GRID_CELLS = 64,
   parameter int MAX_SIDE   = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [fmls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fmls_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_push,
   input  fmls_pkg::req_type                 req_data,
   output logic                              req_full,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output fmls_pkg::rsp_type                 rsp_data
);
   import fmls_pkg::*;

   // Front end: settings, grid position, luma weighting (one stage) and the
   // frame accumulator (one stage). At the last pixel of a frame it pushes the
   // frame's luma total and sample count into the queue and clears its sums.
   // It holds full while the queue is full or has room only for the frame still in flight.
   logic               q_push;
   frame_sum_type      q_push_data;
   logic               q_pop;
   frame_sum_type      q_head;
   queue_status_type   q_status;

   fmls_front #(
      .GRID_CELLS (GRID_CELLS),
      .MAX_SIDE   (MAX_SIDE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_push    (req_push),
      .req_data    (req_data),
      .req_full    (req_full),
      .q_push      (q_push),
      .q_push_data (q_push_data),
      .q_status    (q_status)
   );

   // Queue of finished frame sums: lets pixels keep streaming while the
   // divider works through earlier frames.
   fmls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // Back end: divide the total by tally * 255 one quotient bit a cycle,
   // saturate to full scale, give zero for an empty tally, and hold the result until its transfer.
   fmls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .q_status  (q_status),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ test/frame_mean_luma_sampler_tb.sv @@
// Self-checking bench for the frame mean luma sampler: directed table, then random frames.
`timescale 1ns / 1ps

module frame_mean_luma_sampler_tb;
   import fmls_pkg::*;

   // Block parameters as instantiated (defaults)
   localparam int GRID       = 64;
   localparam int SIDE_LIMIT = 4096;

   // Rec.601 luma weights in Q16; they sum to exactly 65536
   localparam int LUMA_WR    = 19595;
   localparam int LUMA_WG    = 38470;
   localparam int LUMA_WB    = 7471;
   localparam int FULL_SCALE = 65535;

   // A result follows the last pixel of its frame through the queue and the divider; give it room
   // before touching registers
   localparam int DRAIN_CYCLES      = 48;
   localparam int LONG_HOLD         = 400;
   localparam int WATCHDOG_LIMIT    = 3000;
   localparam int OPEN_TAIL         = 200;
   localparam int RANDOM_PIXELS     = 750;
   localparam int MIN_RANDOM_FRAMES = 20;
   localparam int REPORT_LIMIT      = 10;

   // Index with no register behind it: writes must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = CSR_IDX_W'(3);

   typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_W-1:0]    reg_index;
      logic [CSR_DATA_W-1:0]   reg_value;
      req_type                 pixel;
      logic                    pinned;
      rsp_type                 result;
   } stim_row_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    csr_wen   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_push  = 1'b0;
   req_type                 req_data  = '0;
   logic                    req_full;
   logic                    rsp_empty;
   logic                    rsp_pop   = 1'b0;
   rsp_type                 rsp_data;

   // Travels alongside req_data: a hand-typed result for this pixel's frame, if any
   logic                    pinned_use = 1'b0;
   rsp_type                 pinned_rsp = '0;

   // Predictor state, reset values of the block
   logic [CSR_DATA_W-1:0]   cfg_width     = CSR_DATA_W'(64);
   logic [CSR_DATA_W-1:0]   cfg_height    = CSR_DATA_W'(64);
   logic                    cfg_red_first = 1'b0;
   logic [11:0]             col_pos       = '0;
   logic [11:0]             row_pos       = '0;
   logic [5:0]              col_beat      = '0;
   logic [5:0]              row_beat      = '0;
   logic [TOTAL_W-1:0]      luma_sum      = '0;
   logic [TALLY_W-1:0]      kept_count    = '0;
   rsp_type                 mean_expect_q[$];

   int  pixels_sent      = 0;
   int  frames_predicted = 0;
   int  results_checked  = 0;
   int  fault_count      = 0;
   int  quiet_cycles     = 0;
   int  settings_used    = 0;
   int  send_idle_pct    = 0;
   int  pop_idle_pct     = 0;
   logic long_hold_req   = 1'b0;

   // Directed stimulus. Frames of one pixel give one result per transfer, so the
   // extremes and the channel order can be typed in directly: a pure channel at
   // 255 yields its own weight, white saturates to full scale.
   stim_row_type plan [0:24] = '{
      '{ROW_WRITE, CSR_FRAME_WIDTH,  13'd1,    24'h0, 1'b0, 30'h0},
      '{ROW_WRITE, CSR_FRAME_HEIGHT, 13'd1,    24'h0, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'hFF, 8'hFF, 8'hFF}, 1'b1, {16'hFFFF,   14'd1}},
      '{ROW_PIXEL, '0, '0, {8'h00, 8'h00, 8'h00}, 1'b1, {16'd0,      14'd1}},
      '{ROW_PIXEL, '0, '0, {8'hFF, 8'h00, 8'h00}, 1'b1, {16'd7471,   14'd1}},
      '{ROW_PIXEL, '0, '0, {8'h00, 8'hFF, 8'h00}, 1'b1, {16'd38470,  14'd1}},
      '{ROW_PIXEL, '0, '0, {8'h00, 8'h00, 8'hFF}, 1'b1, {16'd19595,  14'd1}},
      '{ROW_WRITE, CSR_RED_FIRST,    13'd1,    24'h0, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'hFF, 8'h00, 8'h00}, 1'b1, {16'd19595,  14'd1}},
      '{ROW_PIXEL, '0, '0, {8'h00, 8'h00, 8'hFF}, 1'b1, {16'd7471,   14'd1}},
      // unmapped index, all data bits set: nothing may change
      '{ROW_WRITE, CSR_UNMAPPED,     13'h1FFF, 24'h0, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h80, 8'h40, 8'hC0}, 1'b0, 30'h0},
      // zero sizes behave as one
      '{ROW_WRITE, CSR_FRAME_WIDTH,  13'd0,    24'h0, 1'b0, 30'h0},
      '{ROW_WRITE, CSR_FRAME_HEIGHT, 13'd0,    24'h0, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h01, 8'h02, 8'h03}, 1'b0, 30'h0},
      '{ROW_WRITE, CSR_FRAME_WIDTH,  13'd3,    24'h0, 1'b0, 30'h0},
      '{ROW_WRITE, CSR_FRAME_HEIGHT, 13'd3,    24'h0, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h12, 8'h34, 8'h56}, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h78, 8'h9A, 8'hBC}, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'hDE, 8'hF0, 8'h11}, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h22, 8'h33, 8'h44}, 1'b0, 30'h0},
      // shrink the row mid-frame: the current row and then the frame end early
      '{ROW_WRITE, CSR_FRAME_WIDTH,  13'd1,    24'h0, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h55, 8'h66, 8'h77}, 1'b0, 30'h0},
      '{ROW_PIXEL, '0, '0, {8'h88, 8'h99, 8'hAA}, 1'b0, 30'h0},
      '{ROW_WRITE, CSR_RED_FIRST,    13'd0,    24'h0, 1'b0, 30'h0}
   };

   frame_mean_luma_sampler u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Zero acts as one, anything above the largest side acts as the largest side
   function automatic int clamp_side(input logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE_LIMIT) return SIDE_LIMIT;
      return int'(v);
   endfunction

   function automatic int grid_step(input int side);
      return (side / GRID == 0) ? 1 : side / GRID;
   endfunction

   // Advance the frame position by one pixel; return 1 with the frame mean when
   // this pixel closes the frame.
   function automatic bit luma_advance(input req_type px, output rsp_type res);
      int     across;
      int     down;
      int     red;
      int     blue;
      int     luma;
      longint quot;
      across = clamp_side(cfg_width);
      down   = clamp_side(cfg_height);
      res    = '0;
      if (col_beat == 0 && row_beat == 0) begin
         red  = cfg_red_first ? int'(px.first_channel) : int'(px.third_channel);
         blue = cfg_red_first ? int'(px.third_channel) : int'(px.first_channel);
         luma = LUMA_WR * red + LUMA_WG * int'(px.middle_channel) + LUMA_WB * blue;
         luma_sum   = luma_sum + TOTAL_W'(luma);
         kept_count = kept_count + 1'b1;
      end
      if (int'(col_pos) + 1 < across) begin
         col_pos  = col_pos + 1'b1;
         col_beat = (int'(col_beat) + 1 >= grid_step(across)) ? '0 : col_beat + 1'b1;
         return 1'b0;
      end
      col_pos  = '0;
      col_beat = '0;
      if (int'(row_pos) + 1 < down) begin
         row_pos  = row_pos + 1'b1;
         row_beat = (int'(row_beat) + 1 >= grid_step(down)) ? '0 : row_beat + 1'b1;
         return 1'b0;
      end
      quot = 0;
      if (kept_count != 0) begin
         quot = longint'(luma_sum) / (longint'(kept_count) * 255);
         if (quot > FULL_SCALE) quot = FULL_SCALE;
      end
      res.mean_brightness = quot[MEAN_W-1:0];
      res.samples_taken   = kept_count;
      row_pos    = '0;
      row_beat   = '0;
      luma_sum   = '0;
      kept_count = '0;
      return 1'b1;
   endfunction

   // Bias towards black and full-scale channels, otherwise any byte
   function automatic logic [CH_W-1:0] any_byte();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CH_W'($urandom);
      endcase
   endfunction

   function automatic req_type any_pixel();
      req_type px;
      px.first_channel  = any_byte();
      px.middle_channel = any_byte();
      px.third_channel  = any_byte();
      return px;
   endfunction

   // Offer one pixel, after an optional idle burst, and hold it until the transfer
   task automatic send_pixel(input req_type px, input logic pin, input rsp_type pinned);
      int gap;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 13);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push   <= 1'b1;
      req_data   <= px;
      pinned_use <= pin;
      pinned_rsp <= pinned;
      do @(posedge clock); while (req_full);
      pixels_sent++;
   endtask

   task automatic send_frames(input int count);
      repeat (count) send_pixel(any_pixel(), 1'b0, '0);
   endtask

   // Stop offering, let every expected result arrive, then let pixels that
   // close no frame drain through the pipeline too
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (mean_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_frame(input int w, input int h, input logic rf);
      settle();
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_RED_FIRST, CSR_DATA_W'(rf));
      settings_used++;
   endtask

   // Whole frames plus an optional tail, which leaves a frame open for the next
   // register change to cut short
   task automatic run_frames(input int w, input int h, input logic rf,
                             input int frames, input int extra);
      program_frame(w, h, rf);
      send_frames(frames * clamp_side(CSR_DATA_W'(w)) * clamp_side(CSR_DATA_W'(h)) + extra);
   endtask

   // Scoreboard: everything is sampled on the rising edge from pre-edge values, so
   // register writes, pixel transfers and result transfers are seen in one place
   always @(posedge clock) begin : score
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) quiet_cycles = 0;
         else quiet_cycles++;

         // check the result transfer first: it can only stem from an earlier pixel
         if (rsp_pop && !rsp_empty) begin
            results_checked++;
            if (mean_expect_q.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected result: mean %0d samples %0d",
                           rsp_data.mean_brightness, rsp_data.samples_taken);
            end else begin
               want = mean_expect_q.pop_front();
               if (rsp_data.mean_brightness !== want.mean_brightness ||
                   rsp_data.samples_taken !== want.samples_taken) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT)
                     $display("result %0d: mean exp %0d got %0d, samples exp %0d got %0d",
                              results_checked, want.mean_brightness,
                              rsp_data.mean_brightness, want.samples_taken,
                              rsp_data.samples_taken);
               end
            end
         end

         if (csr_wen) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg_width     = csr_wdata;
               CSR_FRAME_HEIGHT: cfg_height    = csr_wdata;
               CSR_RED_FIRST:    cfg_red_first = csr_wdata[0];
               default: ;
            endcase
         end

         if (req_push && !req_full) begin
            if (luma_advance(req_data, got)) begin
               // a typed-in row overrides the computed value
               mean_expect_q.insert(mean_expect_q.size(), pinned_use ? pinned_rsp : got);
               frames_predicted++;
            end
         end
      end
   end

   // Result side: random idle bursts, plus one long hold-off so the block backs up
   // into its input
   initial begin : result_sink
      int   hold_left;
      logic long_hold_done;
      hold_left      = 0;
      long_hold_done = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
            rsp_pop <= 1'b0;
         end else if (pop_idle_pct != 0 && $urandom_range(0, 99) < pop_idle_pct) begin
            hold_left = $urandom_range(0, 12);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Abort when neither side has moved a transfer for too long
   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      int w;
      int h;
      int frames;
      int extra;
      int random_start;
      int frames_start;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part: walk the table, settling before every register write
      send_idle_pct = 8;
      pop_idle_pct  = 8;
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) begin
            settle();
            write_reg(plan[i].reg_index, plan[i].reg_value);
         end else begin
            send_pixel(plan[i].pixel, plan[i].pinned, plan[i].result);
         end
      end

      // Widest row with the coarsest column step (a zero height acts as one row),
      // then one pixel wide with an oversize height and the coarsest row step; both
      // stay open so the next register change closes the frame
      run_frames(SIDE_LIMIT, 0, 1'b1, 0, OPEN_TAIL);
      run_frames(1, 8191, 1'b0, 0, OPEN_TAIL);

      // Back-pressure: one-pixel frames while the result side holds off, so the
      // frame-sum queue fills and req_full must rise; keep offering throughout
      send_idle_pct = 0;
      program_frame(1, 1, 1'b1);
      long_hold_req <= 1'b1;
      send_frames(40);

      // Random part: mostly small frames for frequent results, now and then a wide
      // or tall one with grid steps above one, sometimes left open mid-frame
      random_start = pixels_sent;
      frames_start = frames_predicted;
      while (pixels_sent - random_start < RANDOM_PIXELS ||
             frames_predicted - frames_start < MIN_RANDOM_FRAMES) begin
         send_idle_pct = 10 * $urandom_range(0, 2);
         pop_idle_pct  = 10 * $urandom_range(0, 2);
         frames        = $urandom_range(1, 4);
         case ($urandom_range(0, 15))
            0: begin
               w      = $urandom_range(128, 200);
               h      = $urandom_range(0, 1);
               frames = 1;
            end
            1: begin
               w      = $urandom_range(0, 1);
               h      = $urandom_range(128, 200);
               frames = 1;
            end
            default: begin
               w = $urandom_range(0, 9);
               h = $urandom_range(0, 6);
            end
         endcase
         extra = ($urandom_range(0, 3) == 0) ?
                 $urandom_range(1, clamp_side(CSR_DATA_W'(w)) * clamp_side(CSR_DATA_W'(h))) : 0;
         run_frames(w, h, 1'(($urandom_range(0, 1))), frames, extra);
      end

      // Closing stretch: full rate on both sides
      send_idle_pct = 0;
      pop_idle_pct  = 0;
      run_frames(5, 3, 1'b0, 10, 0);
      settle();

      $display("Ran %0d pixels under %0d register settings; %0d frame results checked.",
               pixels_sent, settings_used, results_checked);
      $display("Covered channel order, zero and oversize sides, grid steps to 64, "
               , "mid-frame resizing and a long result stall.");
      if (fault_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
